>>> sv/hdnp_pkg.sv
// Package for the hex/decimal number parser.
// Holds the character constants, the queue sizes, the classified-beat type, enums and the classifier.
// No dependencies.
`default_nettype none

package hdnp_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_H_UP  = 8'h48;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_H_LO  = 8'h68;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;

    localparam logic [8:0] LETTER_BASE = 9'd10;
    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        POS_FIRST     = 2'd0,
        POS_AFTER_NUL = 2'd1,
        POS_SECOND    = 2'd2,
        POS_LATER     = 2'd3
    } t_pos;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } t_phase;

    typedef struct packed {
        logic       last;
        logic       nul;
        logic       zero;
        logic       x;
        logic       h;
        logic       plus;
        logic       minus;
        logic       space;
        logic       digit;
        logic [3:0] dec;
        logic [8:0] dv;     // two's complement digit value, sign-extended downstream
    } t_item;

    function automatic t_item classify(input logic [7:0] c, input logic last);
        t_item it;
        it.last  = last;
        it.nul   = (c == CH_NUL);
        it.zero  = (c == CH_ZERO);
        it.x     = (c == CH_X_LO) || (c == CH_X_UP);
        it.h     = (c == CH_H_LO) || (c == CH_H_UP);
        it.plus  = (c == CH_PLUS);
        it.minus = (c == CH_MINUS);
        it.space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
        it.digit = c inside {[CH_ZERO:CH_NINE]};
        it.dec   = c[3:0];
        if (c inside {[CH_A_UP:CH_Z_UP]}) begin
            it.dv = {1'b0, c} - {1'b0, CH_A_UP} + LETTER_BASE;
        end else if (c inside {[CH_A_LO:CH_Z_LO]}) begin
            it.dv = {1'b0, c} - {1'b0, CH_A_LO} + LETTER_BASE;
        end else begin
            it.dv = {1'b0, c} - {1'b0, CH_ZERO};
        end
        return it;
    endfunction

endpackage

`default_nettype wire

>>> sv/hex_or_decimal_number_parser_core.sv
// Top level of the streaming hex/decimal number parser.
// Instantiates hdnp_front and hdnp_back; depends on hdnp_pkg.
//
//   channel  | side | handshake     | payload
//   ---------+------+---------------+-----------------------------------------
//   chars    | in   | push / full   | i_char_code[7:0], i_is_last
//   results  | out  | empty / pop   | o_value[31:0], o_read_as_hex, o_was_empty
//
// One character per cycle sustained while the back end does not stall; it steps once per beat.
// A last character passes through a queue slot and then the result register before its result is visible.
// A 2-beat queue between front and back lets each side stall on its own;
// the back end only stalls on a last character while a result is still unread.
// Reset is synchronous; after it the queue and the result register are empty.
`default_nettype none

module hex_or_decimal_number_parser_core
    import hdnp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_is_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_value,
    output logic             o_read_as_hex,
    output logic             o_was_empty
);

    t_item w_head;
    logic  w_head_valid;
    logic  w_take;

    hdnp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_char_code  (i_char_code),
        .i_is_last    (i_is_last),
        .i_take       (w_take),
        .o_head       (w_head),
        .o_head_valid (w_head_valid)
    );

    hdnp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_head_valid  (w_head_valid),
        .o_take        (w_take),
        .empty         (empty),
        .pop           (pop),
        .o_value       (o_value),
        .o_read_as_hex (o_read_as_hex),
        .o_was_empty   (o_was_empty)
    );

endmodule

`default_nettype wire

>>> sv/hdnp_front.sv
// Front end: classifies incoming characters and queues them for the back end.
// Depends on hdnp_pkg.
`default_nettype none

module hdnp_front
    import hdnp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_is_last,
    input  wire logic       i_take,
    output t_item           o_head,
    output logic            o_head_valid
);

    t_item                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_rd;
    logic [QUEUE_AW-1:0]  r_wr;
    logic [QUEUE_CW-1:0]  r_count;
    logic                 w_push;
    logic                 w_pop;

    assign full         = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd];
    assign w_push       = push && !full;
    assign w_pop        = i_take && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= classify(i_char_code, i_is_last);
        end
    end

endmodule

`default_nettype wire

>>> sv/hdnp_back.sv
// Back end: runs the hex and decimal accumulations on classified beats and
// holds the finished result in an output register. Depends on hdnp_pkg.
`default_nettype none

module hdnp_back
    import hdnp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_item       i_head,
    input  wire logic   i_head_valid,
    output logic        o_take,
    output logic        empty,
    input  wire logic   pop,
    output logic [31:0] o_value,
    output logic        o_read_as_hex,
    output logic        o_was_empty
);

    t_pos        r_pos,        n_pos;
    logic        r_first_zero, n_first_zero;
    logic        r_prefix,     n_prefix;
    logic [31:0] r_hex_sum,    n_hex_sum;
    logic [31:0] r_hex_full,   n_hex_full;
    logic        r_body,       n_body;
    logic [31:0] r_dec,        n_dec;
    t_phase      r_phase,      n_phase;
    logic        r_neg,        n_neg;
    logic        r_pend_h,     n_pend_h;
    logic        r_term,       n_term;

    logic        r_out_valid;
    logic [31:0] r_value;
    logic        r_hex;
    logic        r_empty;

    logic        w_step;
    logic        w_take_en;
    logic        w_clear;
    logic [31:0] w_dv;
    logic [31:0] w_dec10;
    logic [31:0] w_dig;
    logic [31:0] w_res_value;
    logic        w_res_hex;
    logic        w_res_empty;

    assign w_step  = i_head_valid && (!i_head.last || !r_out_valid || pop);
    assign o_take  = w_step;
    assign w_dv    = {{23{i_head.dv[8]}}, i_head.dv};
    assign w_dec10 = {r_dec[28:0], 3'b000} + {r_dec[30:0], 1'b0};
    assign w_dig   = {28'd0, i_head.dec};

    always_comb begin
        n_pos = r_pos;
        case (r_pos)
            POS_FIRST:     n_pos = i_head.nul ? POS_AFTER_NUL : POS_SECOND;
            POS_AFTER_NUL: n_pos = POS_SECOND;
            POS_SECOND:    n_pos = POS_LATER;
            POS_LATER:     n_pos = POS_LATER;
            default:       n_pos = POS_FIRST;
        endcase
    end

    always_comb begin
        w_take_en    = 1'b0;
        w_clear      = 1'b0;
        n_first_zero = r_first_zero;
        n_prefix     = r_prefix;
        case (r_pos)
            POS_FIRST: begin
                if (!i_head.nul) begin
                    n_first_zero = i_head.zero;
                    w_take_en    = 1'b1;
                end
            end
            POS_AFTER_NUL: begin
                n_first_zero = i_head.zero;
                w_take_en    = 1'b1;
            end
            POS_SECOND: begin
                if (r_first_zero && !r_prefix && !r_term && i_head.x) begin
                    n_prefix = 1'b1;
                    w_clear  = 1'b1;
                end else begin
                    w_take_en = 1'b1;
                end
            end
            default: w_take_en = 1'b1;
        endcase
    end

    always_comb begin
        n_hex_sum  = r_hex_sum;
        n_hex_full = r_hex_full;
        n_body     = r_body;
        n_dec      = r_dec;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_pend_h   = r_pend_h;
        n_term     = r_term;
        if (w_clear) begin
            n_hex_sum  = '0;
            n_hex_full = '0;
            n_body     = 1'b0;
            n_dec      = '0;
            n_phase    = PH_SKIP;
            n_neg      = 1'b0;
            n_pend_h   = 1'b0;
            n_term     = 1'b0;
        end else if (w_take_en && !r_term) begin
            if (i_head.nul) begin
                n_term = 1'b1;
            end else begin
                // hex_full holds the sum including the newest character taken before a NUL terminator
                n_hex_sum  = r_hex_full;
                n_hex_full = {r_hex_full[27:0], 4'b0000} + w_dv;
                n_pend_h   = i_head.h;
                n_body     = 1'b1;
                case (r_phase)
                    PH_SKIP: begin
                        if (i_head.space) begin
                            n_phase = PH_SKIP;
                        end else if (i_head.plus) begin
                            n_phase = PH_DIGITS;
                        end else if (i_head.minus) begin
                            n_neg   = 1'b1;
                            n_phase = PH_DIGITS;
                        end else if (i_head.digit) begin
                            n_dec   = w_dig;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                    PH_DIGITS: begin
                        if (i_head.digit) begin
                            // signed running value: the sign is folded in per digit
                            n_dec = r_neg ? (w_dec10 - w_dig) : (w_dec10 + w_dig);
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    always_comb begin
        w_res_hex   = n_prefix;
        w_res_empty = 1'b0;
        if (!n_body) begin
            w_res_value = EMPTY_VALUE;
            w_res_empty = 1'b1;
        end else if (n_pend_h) begin
            w_res_value = n_hex_sum;
            w_res_hex   = 1'b1;
        end else if (n_prefix) begin
            w_res_value = n_hex_full;
        end else begin
            w_res_value = n_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_step && i_head.last)) begin
            r_pos        <= POS_FIRST;
            r_first_zero <= 1'b0;
            r_prefix     <= 1'b0;
            r_hex_sum    <= '0;
            r_hex_full   <= '0;
            r_body       <= 1'b0;
            r_dec        <= '0;
            r_phase      <= PH_SKIP;
            r_neg        <= 1'b0;
            r_pend_h     <= 1'b0;
            r_term       <= 1'b0;
        end else if (w_step) begin
            r_pos        <= n_pos;
            r_first_zero <= n_first_zero;
            r_prefix     <= n_prefix;
            r_hex_sum    <= n_hex_sum;
            r_hex_full   <= n_hex_full;
            r_body       <= n_body;
            r_dec        <= n_dec;
            r_phase      <= n_phase;
            r_neg        <= n_neg;
            r_pend_h     <= n_pend_h;
            r_term       <= n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && i_head.last) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && i_head.last) begin
            r_value <= w_res_value;
            r_hex   <= w_res_hex;
            r_empty <= w_res_empty;
        end
    end

    assign empty         = !r_out_valid;
    assign o_value       = r_value;
    assign o_read_as_hex = r_hex;
    assign o_was_empty   = r_empty;

endmodule

`default_nettype wire

>>> sv/hdnp_checker.sv
// Port-level checks for hex_or_decimal_number_parser_core, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module hdnp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_value,
    input wire logic        o_read_as_hex,
    input wire logic        o_was_empty
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value) && $stable(o_read_as_hex)
                              && $stable(o_was_empty)))
        else $error("waiting result changed before pop");

    a_empty_body_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_was_empty) |-> (o_value == 32'hFFFF_FFFF))
        else $error("empty body must read as -1");

endmodule

bind hex_or_decimal_number_parser_core hdnp_checker u_hdnp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_value       (o_value),
    .o_read_as_hex (o_read_as_hex),
    .o_was_empty   (o_was_empty)
);

`default_nettype wire
